// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the handshake interface RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GDHI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication violated");

// next-cycle implication
`define GDHI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

// condition that must never hold
`define GDHI_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define GDHI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GDHI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`define GDHI_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/gdhi_pkg.sv =====
// ---------------------------------------------------------------------------
// gdhi_pkg
// Types and constants for the GPIB device handshake interface.
// ---------------------------------------------------------------------------
`default_nettype none

package gdhi_pkg;

  // reply queue geometry
  localparam int QUEUE_DEPTH = 1024;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam logic [QA_W-1:0]  LAST_HEAD = QA_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_LINE    = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_SRQ     = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    LN_ATN  = 2'd0,
    LN_DAV  = 2'd1,
    LN_NRFD = 2'd2,
    LN_NDAC = 2'd3
  } line_t;

  // interface commands
  localparam logic [7:0] GRP_MASK   = 8'hE0;
  localparam logic [7:0] GRP_LISTEN = 8'h20;
  localparam logic [7:0] GRP_TALK   = 8'h40;
  localparam logic [4:0] ADDR_UNL   = 5'h1F;
  localparam logic [7:0] CMD_SPE    = 8'h18;
  localparam logic [7:0] CMD_SPD    = 8'h19;
  localparam logic [7:0] STATUS_RQS = 8'h40;
  localparam logic [7:0] DIO_IDLE   = 8'hFF;

  typedef struct packed {
    logic [7:0] dio;
    logic       srq;
    logic       eoi;
    logic       dav;
    logic       nrfd;
    logic       ndac;
  } drive_t;

  typedef struct packed {
    logic       enq_dropped;
    logic       msg_done;
    logic [7:0] rx_byte;
    logic       rx_valid;
    drive_t     drv;
  } result_t;

  typedef struct packed {
    logic empty;
    logic one;
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gdhi_reply_queue.sv =====
// ---------------------------------------------------------------------------
// gdhi_reply_queue
// Circular reply byte queue in a single-port synchronous RAM with a
// registered read; the read register holds the last popped byte.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gdhi_reply_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_en,
  input  wire logic [7:0]      push_data,
  input  wire logic            pop_en,
  output gdhi_pkg::qstat_t     status,
  output logic [7:0]           rd_data
);

  logic [7:0] mem [gdhi_pkg::QUEUE_DEPTH];

  logic [gdhi_pkg::QA_W-1:0]  head_r, head_nxt;
  logic [gdhi_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [7:0]                 rd_data_r;

  logic [gdhi_pkg::SUM_W-1:0] tail_sum;
  logic [gdhi_pkg::SUM_W-1:0] tail_wrapped;
  logic [gdhi_pkg::QA_W-1:0]  tail;

  assign tail_sum = {{(gdhi_pkg::SUM_W - gdhi_pkg::QA_W){1'b0}}, head_r}
                  + {1'b0, count_r};
  assign tail_wrapped = (tail_sum >= gdhi_pkg::DEPTH_SUM) ?
                        (tail_sum - gdhi_pkg::DEPTH_SUM) : tail_sum;
  assign tail = tail_wrapped[gdhi_pkg::QA_W-1:0];

  assign status.empty = (count_r == '0);
  assign status.one   = (count_r == gdhi_pkg::CNT_ONE);
  assign status.full  = (count_r == gdhi_pkg::DEPTH_CNT);
  assign rd_data      = rd_data_r;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (pop_en) begin
      head_nxt  = (head_r == gdhi_pkg::LAST_HEAD) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (push_en) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[tail] <= push_data;
    end
    if (pop_en) begin
      rd_data_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  `GDHI_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop_en && status.empty)
  `GDHI_ASSERT_NEVER(a_push_full, clk, rst_n, push_en && status.full)
  `GDHI_ASSERT_NEVER(a_push_pop, clk, rst_n, push_en && pop_en)
  `GDHI_ASSERT_NEVER(a_count_range, clk, rst_n, count_r > gdhi_pkg::DEPTH_CNT)

endmodule

`default_nettype wire

// ===== hw/rtl/gdhi_out_skid.sv =====
// ---------------------------------------------------------------------------
// gdhi_out_skid
// Output register plus one skid entry for the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gdhi_out_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  gdhi_pkg::result_t      push_data,
  output logic                   ready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output gdhi_pkg::result_t      out_data
);

  logic              out_valid_r;
  logic              skid_valid_r;
  gdhi_pkg::result_t out_data_r;
  gdhi_pkg::result_t skid_data_r;

  assign ready      = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
          out_data_r  <= push_data;
        end else begin
          // hold the new item aside while the output stalls
          skid_valid_r <= 1'b1;
          skid_data_r  <= push_data;
        end
      end else if (out_valid_r && out_tready) begin
        if (skid_valid_r) begin
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  `GDHI_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `GDHI_ASSERT_NEVER(a_push_skid_full, clk, rst_n, push && skid_valid_r)
  `GDHI_ASSERT_NXT(a_push_shows, clk, rst_n, push, out_valid_r)

endmodule

`default_nettype wire

// ===== hw/rtl/gpib_device_handshake_interface_top.sv =====
// ---------------------------------------------------------------------------
// gpib_device_handshake_interface_top
// Device side of the GPIB three-wire handshake: acceptor, source, address
// decode, serial poll and a reply byte queue.
// ---------------------------------------------------------------------------
// Channel  | Dir | Handshake              | Payload
// in_      | in  | in_tvalid / in_tready  | tuser: operation; tdata: line event,
//          |     |                        |   sampled bus, reply byte
// out_     | out | out_tvalid / out_tready| line drives, rx byte, status flags
// cfg_     | in  | cfg_wr_en              | bus_address
//
// One item per clock while in_tready is high; each item's result sits on out_tdata the cycle after
// it is accepted unless the output stalls, then it waits in the skid entry.
// The rate is set by the combinational event decision and the
// one-port reply RAM (one push or one pop per item, read data registered).
// A popped byte is taken from the RAM read register on a later item.
// Reset is synchronous and takes effect at once; the queue RAM is not cleared.
// The output register and a skid entry hold two items; in_tready drops only
// when both are occupied.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gpib_device_handshake_interface_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // line_id[1:0], line_level[2], bus_data[10:3],
                                       // eoi_level[11], data_byte[19:12], zero[23:20]
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // ndac_drive[0], nrfd_drive[1], dav_drive[2],
                                       // eoi_drive[3], srq_drive[4], dio_drive[12:5],
                                       // rx_valid[13], rx_byte[21:14],
                                       // message_done[22], enqueue_dropped[23]
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_DAV_HIGH,
    PH_SEND_START,
    PH_WAIT_NDAC_HIGH,
    PH_WAIT_ATN_HIGH
  } phase_t;

  // item fields
  gdhi_pkg::op_t   in_op;
  gdhi_pkg::line_t in_line;
  logic            in_level;
  logic [7:0]      in_bus_data;
  logic            in_eoi_level;
  logic [7:0]      in_data_byte;

  assign in_op        = gdhi_pkg::op_t'(in_tuser);
  assign in_line      = gdhi_pkg::line_t'(in_tdata[1:0]);
  assign in_level     = in_tdata[2];
  assign in_bus_data  = in_tdata[10:3];
  assign in_eoi_level = in_tdata[11];
  assign in_data_byte = in_tdata[19:12];

  // state
  logic [4:0]       bus_address_r;
  phase_t           phase_r, phase_nxt;
  logic [3:0]       lines_r, lines_nxt;
  logic             listener_r, listener_nxt;
  logic             talker_r, talker_nxt;
  logic             poll_r, poll_nxt;
  logic             srq_pending_r, srq_pending_nxt;
  logic [7:0]       poll_status_r, poll_status_nxt;
  logic [7:0]       last_byte_r, last_byte_nxt;
  logic             last_cmd_r, last_cmd_nxt;
  logic             last_eoi_r, last_eoi_nxt;
  logic [7:0]       send_byte_r, send_byte_nxt;
  logic             send_from_q_r, send_from_q_nxt;
  logic             send_eoi_r, send_eoi_nxt;
  gdhi_pkg::drive_t drv_r, drv_nxt;

  // step outputs
  logic              accept;
  logic              pop, push, dropped, got, done;
  logic [7:0]        got_value;
  logic              nrfd_call, nrfd_lvl, ndac_call, ndac_lvl;
  logic [7:0]        send_byte_cur;
  gdhi_pkg::qstat_t  qstat;
  logic [7:0]        q_rd_data;
  gdhi_pkg::result_t result;
  gdhi_pkg::result_t out_result;
  logic              skid_ready;

  assign accept        = in_tvalid && in_tready;
  assign in_tready     = skid_ready;
  assign send_byte_cur = send_from_q_r ? q_rd_data : send_byte_r;

  always_comb begin
    phase_nxt       = phase_r;
    lines_nxt       = lines_r;
    listener_nxt    = listener_r;
    talker_nxt      = talker_r;
    poll_nxt        = poll_r;
    srq_pending_nxt = srq_pending_r;
    poll_status_nxt = poll_status_r;
    last_byte_nxt   = last_byte_r;
    last_cmd_nxt    = last_cmd_r;
    last_eoi_nxt    = last_eoi_r;
    send_byte_nxt   = send_byte_r;
    send_from_q_nxt = send_from_q_r;
    send_eoi_nxt    = send_eoi_r;
    drv_nxt         = drv_r;
    pop             = 1'b0;
    push            = 1'b0;
    dropped         = 1'b0;
    got             = 1'b0;
    got_value       = 8'h00;
    done            = 1'b0;
    nrfd_call       = 1'b0;
    nrfd_lvl        = 1'b0;
    ndac_call       = 1'b0;
    ndac_lvl        = 1'b0;

    unique case (in_op)
      gdhi_pkg::OP_LINE: begin
        if (lines_r[in_line] != in_level) begin
          lines_nxt[in_line] = in_level;
          if (in_line == gdhi_pkg::LN_DAV) begin
            if (!in_level && phase_r == PH_IDLE) begin
              // acceptor: take the byte, hold off further data
              drv_nxt.nrfd  = 1'b0;
              drv_nxt.dio   = gdhi_pkg::DIO_IDLE;
              last_cmd_nxt  = !lines_r[gdhi_pkg::LN_ATN];
              last_byte_nxt = ~in_bus_data;
              if (lines_r[gdhi_pkg::LN_ATN]) begin
                last_eoi_nxt = !in_eoi_level;
              end
              drv_nxt.ndac = 1'b1;
              phase_nxt    = PH_WAIT_DAV_HIGH;
            end else if (in_level && phase_r == PH_WAIT_DAV_HIGH) begin
              phase_nxt    = PH_IDLE;
              drv_nxt.ndac = !(last_cmd_r || listener_r);
              drv_nxt.nrfd = 1'b1;
              if (last_cmd_r) begin
                if ((last_byte_r & gdhi_pkg::GRP_MASK) == gdhi_pkg::GRP_LISTEN) begin
                  if (last_byte_r[4:0] == bus_address_r) begin
                    listener_nxt = 1'b1;
                  end else if (last_byte_r[4:0] == gdhi_pkg::ADDR_UNL) begin
                    listener_nxt = 1'b0;
                    done         = last_eoi_r;
                  end
                end else if ((last_byte_r & gdhi_pkg::GRP_MASK) == gdhi_pkg::GRP_TALK) begin
                  talker_nxt = (last_byte_r[4:0] == bus_address_r);
                end else if (last_byte_r == gdhi_pkg::CMD_SPE) begin
                  poll_nxt = 1'b1;
                end else if (last_byte_r == gdhi_pkg::CMD_SPD) begin
                  poll_nxt = 1'b0;
                end
              end else if (listener_r) begin
                got       = 1'b1;
                got_value = last_byte_r;
              end
              if (talker_nxt) begin
                if (poll_nxt) begin
                  if (srq_pending_r) begin
                    srq_pending_nxt = 1'b0;
                    drv_nxt.srq     = 1'b1;
                  end
                  send_byte_nxt   = poll_status_r
                                  | (srq_pending_r ? gdhi_pkg::STATUS_RQS : 8'h00);
                  send_from_q_nxt = 1'b0;
                  poll_status_nxt = 8'h00;
                  send_eoi_nxt    = 1'b0;
                  phase_nxt       = PH_SEND_START;
                end else if (!qstat.empty) begin
                  pop             = 1'b1;
                  send_from_q_nxt = 1'b1;
                  send_eoi_nxt    = qstat.one;
                  phase_nxt       = PH_WAIT_ATN_HIGH;
                end
              end
            end
          end else begin
            // ATN release may resume a pending source handshake
            if (in_line == gdhi_pkg::LN_ATN && in_level && phase_r == PH_WAIT_ATN_HIGH) begin
              phase_nxt = PH_SEND_START;
              nrfd_call = 1'b1;
              nrfd_lvl  = lines_r[gdhi_pkg::LN_NRFD];
            end
            if (in_line == gdhi_pkg::LN_NRFD) begin
              nrfd_call = 1'b1;
              nrfd_lvl  = in_level;
            end
            if (nrfd_call && nrfd_lvl && phase_nxt == PH_SEND_START) begin
              drv_nxt.dio  = ~send_byte_cur;
              drv_nxt.eoi  = !send_eoi_r;
              drv_nxt.dav  = 1'b0;
              drv_nxt.ndac = 1'b1;
              phase_nxt    = PH_WAIT_NDAC_HIGH;
              ndac_call    = 1'b1;
              ndac_lvl     = lines_r[gdhi_pkg::LN_NDAC];
            end
            if (in_line == gdhi_pkg::LN_NDAC) begin
              ndac_call = 1'b1;
              ndac_lvl  = in_level;
            end
            if (ndac_call && ndac_lvl && phase_nxt == PH_WAIT_NDAC_HIGH) begin
              drv_nxt.dav  = 1'b1;
              drv_nxt.eoi  = 1'b1;
              drv_nxt.nrfd = 1'b1;
              phase_nxt    = PH_IDLE;
              if (poll_r) begin
                talker_nxt   = 1'b0;
                drv_nxt.ndac = 1'b0;
              end else begin
                drv_nxt.ndac = !(!lines_nxt[gdhi_pkg::LN_ATN] || listener_r);
              end
              if (!poll_r && talker_r && !qstat.empty) begin
                pop             = 1'b1;
                send_from_q_nxt = 1'b1;
                send_eoi_nxt    = qstat.one;
                phase_nxt       = PH_SEND_START;
              end else begin
                drv_nxt.dio = gdhi_pkg::DIO_IDLE;
              end
            end
            if (in_line == gdhi_pkg::LN_ATN && phase_nxt == PH_IDLE) begin
              drv_nxt.ndac = !(!in_level || listener_r);
            end
          end
        end
      end
      gdhi_pkg::OP_ENQUEUE: begin
        if (qstat.full) begin
          dropped = 1'b1;
        end else begin
          push = 1'b1;
        end
      end
      gdhi_pkg::OP_SRQ: begin
        poll_status_nxt = in_data_byte;
        srq_pending_nxt = 1'b1;
        drv_nxt.srq     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.enq_dropped = dropped;
    result.msg_done    = done;
    result.rx_byte     = got_value;
    result.rx_valid    = got;
    result.drv         = drv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_address_r <= 5'd5;
      phase_r       <= PH_IDLE;
      lines_r       <= 4'hF;
      listener_r    <= 1'b0;
      talker_r      <= 1'b0;
      poll_r        <= 1'b0;
      srq_pending_r <= 1'b0;
      poll_status_r <= 8'h00;
      last_byte_r   <= 8'h00;
      last_cmd_r    <= 1'b0;
      last_eoi_r    <= 1'b0;
      send_byte_r   <= 8'h00;
      send_from_q_r <= 1'b0;
      send_eoi_r    <= 1'b0;
      drv_r         <= '1;
    end else begin
      if (cfg_wr_en) begin
        bus_address_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r       <= phase_nxt;
        lines_r       <= lines_nxt;
        listener_r    <= listener_nxt;
        talker_r      <= talker_nxt;
        poll_r        <= poll_nxt;
        srq_pending_r <= srq_pending_nxt;
        poll_status_r <= poll_status_nxt;
        last_byte_r   <= last_byte_nxt;
        last_cmd_r    <= last_cmd_nxt;
        last_eoi_r    <= last_eoi_nxt;
        send_byte_r   <= send_byte_nxt;
        send_from_q_r <= send_from_q_nxt;
        send_eoi_r    <= send_eoi_nxt;
        drv_r         <= drv_nxt;
      end
    end
  end

  gdhi_reply_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (accept && push),
    .push_data (in_data_byte),
    .pop_en    (accept && pop),
    .status    (qstat),
    .rd_data   (q_rd_data)
  );

  gdhi_out_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (result),
    .ready      (skid_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_result)
  );

  assign out_tdata = out_result;

  `GDHI_ASSERT_NXT(a_accept_result, clk, rst_n, accept, out_tvalid)
  `GDHI_ASSERT_IMP(a_dav_only_sending, clk, rst_n, !drv_r.dav, phase_r == PH_WAIT_NDAC_HIGH)
  `GDHI_ASSERT_IMP(a_srq_matches, clk, rst_n, 1'b1, drv_r.srq == !srq_pending_r)

endmodule

`default_nettype wire

// ===== tb/gpib_device_handshake_interface_top_tb.sv =====
// ---------------------------------------------------------------------------
// GPIB device handshake interface testbench
// Feeds bus line events, reply bytes and service requests into the block and
// checks every result against a local model of the acceptor, the source, the
// address decode, the serial poll and the reply queue. The run steps through
// several bus addresses, including both ends of the range and address 30.
// ---------------------------------------------------------------------------
module gpib_device_handshake_interface_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gdhi_pkg::*;

  localparam int STUCK_LIMIT = 5000;
  localparam int REPORT_MAX  = 10;
  localparam result_t RELEASED = result_t'(24'h001FFF);

  typedef enum logic [2:0] {
    HS_IDLE,
    HS_HOLD_DATA,
    HS_SRC_ARMED,
    HS_SRC_WAIT_ACCEPT,
    HS_SRC_WAIT_ATN
  } hs_phase_t;

  typedef struct {
    op_t        op;
    line_t      lid;
    logic       lvl;
    logic [7:0] bus;
    logic       eoi;
    logic [7:0] reply;
  } bus_item_t;

  typedef struct {
    bus_item_t it;
    bit        fixed;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;

  gpib_device_handshake_interface_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // device model state
  logic [4:0]      my_addr;
  hs_phase_t       phase;
  logic [3:0]      lines_lv;
  bit              listener, talker, polled, srq_wait;
  logic [7:0]      poll_byte, rx_last, tx_byte;
  bit              rx_was_cmd, rx_eoi, tx_last;
  logic [7:0]      reply_mem [QUEUE_DEPTH];
  logic [QA_W-1:0] q_head;
  int unsigned     q_count;
  drive_t          drv;
  bit              got_rx, got_done;
  logic [7:0]      got_rx_byte;

  result_t     exp_responses[$];
  table_row_t  directed[$];
  int unsigned items_sent, results_seen, fail_count, stuck;
  int unsigned rx_count, done_count, drop_count;
  bit          no_gaps, no_stall;

  function automatic void reset_model();
    my_addr    = 5'd5;
    phase      = HS_IDLE;
    lines_lv   = 4'hF;
    listener   = 0;
    talker     = 0;
    polled     = 0;
    srq_wait   = 0;
    poll_byte  = '0;
    rx_last    = '0;
    rx_was_cmd = 0;
    rx_eoi     = 0;
    tx_byte    = '0;
    tx_last    = 0;
    q_head     = '0;
    q_count    = 0;
    drv        = '1;
  endfunction

  function automatic void acceptor_ndac(bit atn_on);
    if (phase == HS_IDLE) drv.ndac = !(atn_on || listener);
  endfunction

  function automatic logic [7:0] pop_reply();
    logic [7:0] v;
    v = reply_mem[q_head];
    q_head = (q_head == LAST_HEAD) ? '0 : q_head + 1'b1;
    q_count--;
    return v;
  endfunction

  function automatic void source_accepted(logic lvl);
    if (lvl != 1'b1 || phase != HS_SRC_WAIT_ACCEPT) return;
    drv.dav  = 1'b1;
    drv.eoi  = 1'b1;
    drv.nrfd = 1'b1;
    phase    = HS_IDLE;
    if (polled) begin
      talker   = 0;
      drv.ndac = 1'b0;
    end else begin
      acceptor_ndac(lines_lv[LN_ATN] == 1'b0);
    end
    if (!polled && talker && q_count != 0) begin
      tx_byte = pop_reply();
      tx_last = (q_count == 0);
      phase   = HS_SRC_ARMED;
    end else begin
      drv.dio = DIO_IDLE;
    end
  endfunction

  function automatic void source_put(logic lvl);
    if (lvl != 1'b1 || phase != HS_SRC_ARMED) return;
    drv.dio  = ~tx_byte;
    drv.eoi  = !tx_last;
    drv.dav  = 1'b0;
    drv.ndac = 1'b1;
    phase    = HS_SRC_WAIT_ACCEPT;
    source_accepted(lines_lv[LN_NDAC]);
  endfunction

  function automatic void atn_change(logic lvl);
    if (lvl && phase == HS_SRC_WAIT_ATN) begin
      phase = HS_SRC_ARMED;
      source_put(lines_lv[LN_NRFD]);
    end
    acceptor_ndac(!lvl);
  endfunction

  function automatic void decode_cmd();
    logic [4:0] a;
    a = rx_last[4:0];
    if ((rx_last & GRP_MASK) == GRP_LISTEN) begin
      // own address wins over unlisten when both are 31
      if (a == my_addr) begin
        listener = 1;
      end else if (a == ADDR_UNL) begin
        listener = 0;
        if (rx_eoi) got_done = 1;
      end
    end else if ((rx_last & GRP_MASK) == GRP_TALK) begin
      talker = (a == my_addr);
    end else if (rx_last == CMD_SPE) begin
      polled = 1;
    end else if (rx_last == CMD_SPD) begin
      polled = 0;
    end
  endfunction

  function automatic void dav_change(logic lvl, logic [7:0] bus, logic eoi);
    bit had;
    if (!lvl && phase == HS_IDLE) begin
      drv.nrfd   = 1'b0;
      drv.dio    = DIO_IDLE;
      rx_was_cmd = (lines_lv[LN_ATN] == 1'b0);
      rx_last    = ~bus;
      if (!rx_was_cmd) rx_eoi = !eoi;
      drv.ndac   = 1'b1;
      phase      = HS_HOLD_DATA;
    end else if (lvl && phase == HS_HOLD_DATA) begin
      phase = HS_IDLE;
      acceptor_ndac(rx_was_cmd);
      drv.nrfd = 1'b1;
      if (rx_was_cmd) begin
        decode_cmd();
      end else if (listener) begin
        got_rx      = 1;
        got_rx_byte = rx_last;
      end
      if (talker) begin
        if (polled) begin
          had = srq_wait;
          if (had) begin
            srq_wait = 0;
            drv.srq  = 1'b1;
          end
          tx_byte   = poll_byte | (had ? STATUS_RQS : 8'h00);
          poll_byte = '0;
          tx_last   = 0;
          phase     = HS_SRC_ARMED;
        end else if (q_count != 0) begin
          tx_byte = pop_reply();
          tx_last = (q_count == 0);
          phase   = HS_SRC_WAIT_ATN;
        end
      end
    end
  endfunction

  function automatic result_t bus_response(bus_item_t it);
    result_t r;
    got_rx      = 0;
    got_rx_byte = '0;
    got_done    = 0;
    r = '0;
    case (it.op)
      OP_LINE: begin
        if (lines_lv[it.lid] != it.lvl) begin
          lines_lv[it.lid] = it.lvl;
          case (it.lid)
            LN_ATN:  atn_change(it.lvl);
            LN_DAV:  dav_change(it.lvl, it.bus, it.eoi);
            LN_NRFD: source_put(it.lvl);
            default: source_accepted(it.lvl);
          endcase
        end
      end
      OP_ENQUEUE: begin
        if (q_count >= QUEUE_DEPTH) begin
          r.enq_dropped = 1'b1;
        end else begin
          reply_mem[(q_head + q_count) % QUEUE_DEPTH] = it.reply;
          q_count++;
        end
      end
      OP_SRQ: begin
        poll_byte = it.reply;
        srq_wait  = 1;
        drv.srq   = 1'b0;
      end
      default: ;
    endcase
    r.drv      = drv;
    r.rx_valid = got_rx;
    r.rx_byte  = got_rx_byte;
    r.msg_done = got_done;
    return r;
  endfunction

  function automatic bus_item_t mk(op_t op, line_t lid, logic lvl, logic [7:0] bus,
                                   logic eoi, logic [7:0] reply);
    bus_item_t it;
    it.op    = op;
    it.lid   = lid;
    it.lvl   = lvl;
    it.bus   = bus;
    it.eoi   = eoi;
    it.reply = reply;
    return it;
  endfunction

  function automatic bus_item_t line_ev(line_t lid, logic lvl, logic [7:0] bus);
    return mk(OP_LINE, lid, lvl, bus, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endfunction

  function automatic bus_item_t reply_ev(op_t op, logic [7:0] reply);
    return mk(op, line_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), reply);
  endfunction

  function automatic void add_row(bus_item_t it, bit fixed = 0);
    table_row_t row;
    row.it    = it;
    row.fixed = fixed;
    directed.insert(directed.size(), row);
  endfunction

  task automatic send_item(bus_item_t it, bit fixed = 0);
    result_t r;
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 34) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {4'h0, it.reply, it.eoi, it.bus, it.lvl, it.lid};
    do @(posedge clk); while (!in_tready);
    r = bus_response(it);
    exp_responses.insert(exp_responses.size(), fixed ? RELEASED : r);
    items_sent++;
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic set_address(logic [4:0] a);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    my_addr = a;
  endtask

  task automatic cmd_cycle(logic [7:0] cmd);
    if (lines_lv[LN_ATN]) send_item(line_ev(LN_ATN, 1'b0, 8'($urandom_range(0, 255))));
    send_item(line_ev(LN_DAV, 1'b0, ~cmd));
    send_item(line_ev(LN_DAV, 1'b1, 8'($urandom_range(0, 255))));
  endtask

  task automatic data_cycle();
    if (!lines_lv[LN_ATN]) send_item(line_ev(LN_ATN, 1'b1, 8'($urandom_range(0, 255))));
    send_item(line_ev(LN_DAV, 1'b0, 8'($urandom_range(0, 255))));
    send_item(line_ev(LN_DAV, 1'b1, 8'($urandom_range(0, 255))));
  endtask

  // controller acting as acceptor for one byte from the device
  task automatic source_cycle();
    send_item(line_ev(LN_NDAC, 1'b0, 8'($urandom_range(0, 255))));
    send_item(line_ev(LN_NRFD, 1'b0, 8'($urandom_range(0, 255))));
    send_item(line_ev(LN_NRFD, 1'b1, 8'($urandom_range(0, 255))));
    send_item(line_ev(LN_NDAC, 1'b1, 8'($urandom_range(0, 255))));
  endtask

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 9))
      0, 1:    return GRP_LISTEN | my_addr;
      2:       return GRP_LISTEN | 8'($urandom_range(0, 31));
      3:       return GRP_LISTEN | ADDR_UNL;
      4, 5:    return GRP_TALK | my_addr;
      6:       return GRP_TALK | 8'($urandom_range(0, 31));
      7:       return CMD_SPE;
      8:       return CMD_SPD;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_phase(int unsigned count);
    int unsigned target, pick, n;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        cmd_cycle(pick_cmd());
      end else if (pick < 40) begin
        data_cycle();
      end else if (pick < 55) begin
        source_cycle();
      end else if (pick < 65) begin
        send_item(reply_ev(OP_ENQUEUE, 8'($urandom_range(0, 255))));
      end else if (pick < 70) begin
        send_item(reply_ev(OP_SRQ, 8'($urandom_range(0, 255))));
      end else if (pick < 78) begin
        // serial poll of this device
        if ($urandom_range(0, 1)) send_item(reply_ev(OP_SRQ, 8'($urandom_range(0, 255))));
        cmd_cycle(CMD_SPE);
        cmd_cycle(GRP_TALK | my_addr);
        source_cycle();
        cmd_cycle(CMD_SPD);
        cmd_cycle(GRP_TALK | ADDR_UNL);
      end else if (pick < 88) begin
        // queued reply read out by the controller
        n = $urandom_range(1, 4);
        repeat (n) send_item(reply_ev(OP_ENQUEUE, 8'($urandom_range(0, 255))));
        cmd_cycle(GRP_TALK | my_addr);
        send_item(line_ev(LN_ATN, 1'b1, 8'($urandom_range(0, 255))));
        repeat (n) source_cycle();
      end else begin
        send_item(mk(op_t'($urandom_range(0, 3)), line_t'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
      end
    end
  endtask

  always @(posedge clk) begin
    out_tready <= no_stall || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin : check_results
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      rx_count   += got.rx_valid;
      done_count += got.msg_done;
      drop_count += got.enq_dropped;
      if (exp_responses.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("unexpected result %h", got);
      end else begin
        want = exp_responses.pop_front();
        if (got.drv !== want.drv || got.rx_valid !== want.rx_valid ||
            got.rx_byte !== want.rx_byte || got.msg_done !== want.msg_done ||
            got.enq_dropped !== want.enq_dropped) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("result %0d: drives exp %h got %h, rx exp %b/%h got %b/%h, done exp %b got %b, drop exp %b got %b",
                     results_seen, want.drv, got.drv, want.rx_valid, want.rx_byte,
                     got.rx_valid, got.rx_byte, want.msg_done, got.msg_done,
                     want.enq_dropped, got.enq_dropped);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    reset_model();
    no_gaps  = 0;
    no_stall = 0;

    // directed table, address 5 after reset
    add_row(mk(OP_NOP, LN_ATN, 1'b0, 8'h00, 1'b0, 8'h00), 1);
    add_row(mk(OP_LINE, LN_NDAC, 1'b1, 8'h00, 1'b0, 8'hFF), 1);
    add_row(mk(OP_LINE, LN_ATN, 1'b0, 8'hFF, 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_DAV, 1'b0, ~(GRP_LISTEN | 8'h05), 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_DAV, 1'b1, 8'h00, 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_ATN, 1'b1, 8'h00, 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_DAV, 1'b0, 8'hFF, 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_DAV, 1'b1, 8'h00, 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_DAV, 1'b0, 8'h00, 1'b0, 8'h00));
    add_row(mk(OP_LINE, LN_DAV, 1'b1, 8'hFF, 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_ATN, 1'b0, 8'h00, 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_DAV, 1'b0, ~(GRP_LISTEN | ADDR_UNL), 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_DAV, 1'b1, 8'h00, 1'b1, 8'h00));
    // unlisten again without new data
    add_row(mk(OP_LINE, LN_DAV, 1'b0, ~(GRP_LISTEN | ADDR_UNL), 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_DAV, 1'b1, 8'h00, 1'b1, 8'h00));
    add_row(mk(OP_ENQUEUE, LN_ATN, 1'b0, 8'h00, 1'b0, 8'h00));
    add_row(mk(OP_ENQUEUE, LN_NDAC, 1'b1, 8'hFF, 1'b1, 8'hFF));
    add_row(mk(OP_SRQ, LN_DAV, 1'b0, 8'h00, 1'b0, 8'h81));
    add_row(mk(OP_LINE, LN_DAV, 1'b0, ~(GRP_TALK | 8'h05), 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_DAV, 1'b1, 8'h00, 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_ATN, 1'b1, 8'h00, 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_NRFD, 1'b0, 8'h00, 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_NRFD, 1'b1, 8'h00, 1'b1, 8'h00));
    add_row(mk(OP_LINE, LN_ATN, 1'b0, 8'h00, 1'b1, 8'h00));
    add_row(mk(OP_NOP, LN_NDAC, 1'b1, 8'hFF, 1'b1, 8'hFF));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i].it, directed[i].fixed);

    // long stretch with neither side idling
    no_gaps  = 1;
    no_stall = 1;
    random_phase(150);
    no_gaps  = 0;
    no_stall = 0;

    set_address(5'd0);
    random_phase(115);
    set_address(5'd30);
    random_phase(115);
    set_address(5'd31);
    random_phase(115);

    set_address(5'($urandom_range(1, 29)));
    random_phase(115);

    drain();
    repeat (10) @(posedge clk);
    fail_count += exp_responses.size();
    $display("Ran %0d items through five bus addresses.", items_sent);
    $display("Results: %0d checked, %0d bytes listened, %0d messages done, %0d drops.",
             results_seen, rx_count, done_count, drop_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== gpib_device_handshake_interface_top.f =====
+incdir+hw/rtl
hw/rtl/gdhi_pkg.sv
hw/rtl/gdhi_reply_queue.sv
hw/rtl/gdhi_out_skid.sv
hw/rtl/gpib_device_handshake_interface_top.sv
tb/gpib_device_handshake_interface_top_tb.sv
